[hw/rtl/sfr_pkg.sv]
// shared constants, types and helper functions for the stream find/replace block
package sfr_pkg;

	localparam int MAX_PATTERN     = 8;
	localparam int MAX_REPLACEMENT = 8;
	localparam int WIN_DEPTH       = MAX_PATTERN + 1;
	localparam int CAP_A           = MAX_REPLACEMENT + MAX_PATTERN + 1;
	localparam int CAP_B           = 2 * MAX_REPLACEMENT;
	localparam int RESULT_CAP      = (CAP_A > CAP_B) ? CAP_A : CAP_B;

	localparam int LEN_W  = 4;
	localparam int FILL_W = $clog2(WIN_DEPTH + 1);
	localparam int WIN_W  = $clog2(WIN_DEPTH);
	localparam int CNT_W  = $clog2(RESULT_CAP + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int REG_W  = 64;
	localparam int CIDX_W = 3;

	localparam logic [CIDX_W-1:0] CFG_PAT_BYTES = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_PAT_LEN   = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_REP_BYTES = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_REP_LEN   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_WHOLE_WRD = 3'd4;

	typedef struct packed {
		logic load;
		logic idx_clr;
		logic idx_inc;
		logic drop;
		logic shift1;
		logic put_w0;
		logic put_rep;
		logic fin;
	} sfr_cmd_t;

	typedef struct packed {
		logic last;
		logic fill_ge_need;
		logic fill_zero;
		logic match;
		logic take_ok;
		logic rlen_zero;
		logic rep_end;
		logic copy_end;
		logic put_ok;
		logic fin_ok;
	} sfr_sts_t;

	function automatic logic is_alnum(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
			(b >= 8'h61 && b <= 8'h7a);
	endfunction

	function automatic logic [7:0] reg_byte(input logic [REG_W-1:0] r,
		input logic [LEN_W-1:0] k);
		logic [7:0] res;
		res = 8'h00;
		if (k < LEN_W'(REG_W / 8))
			res = r[8*k +: 8];
		return res;
	endfunction

endpackage

[hw/rtl/sfr_dp.sv]
// datapath: configuration registers, byte window, match logic and output registers
module sfr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sfr_pkg::sfr_cmd_t             cmd,
	output sfr_pkg::sfr_sts_t             sts,
	input  logic                          cfg_we,
	input  logic [sfr_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [sfr_pkg::REG_W-1:0]     cfg_data,
	input  logic [7:0]                    text_byte,
	input  logic                          text_last,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [7:0]                    emit_byte,
	output logic                          emit_valid,
	output logic                          emit_last
);

	logic [sfr_pkg::REG_W-1:0] pat_q;
	logic [sfr_pkg::REG_W-1:0] rep_q;
	logic [sfr_pkg::LEN_W-1:0] pat_len_q;
	logic [sfr_pkg::LEN_W-1:0] rep_len_q;
	logic                      ww_q;

	logic [7:0]                 w_q [sfr_pkg::WIN_DEPTH];
	logic [7:0]                 w_drop [sfr_pkg::WIN_DEPTH];
	logic [sfr_pkg::FILL_W-1:0] fill_q;
	logic                       before_q;
	logic                       last_q;
	logic [sfr_pkg::CNT_W-1:0]  cnt_q;
	logic [sfr_pkg::LEN_W-1:0]  idx_q;

	logic       out_vld_q;
	logic [7:0] out_byte_q;
	logic       out_bv_q;
	logic       out_last_q;
	logic       pend_vld_q;
	logic [7:0] pend_q;

	logic [sfr_pkg::LEN_W-1:0]  plen;
	logic [sfr_pkg::LEN_W-1:0]  rlen;
	logic [sfr_pkg::FILL_W-1:0] need;
	logic                       match;
	logic                       after;
	logic                       take;
	logic [sfr_pkg::SUM_W-1:0]  total;
	logic                       out_free;
	logic                       put;
	logic [7:0]                 put_data;
	logic                       out_load;
	logic [7:0]                 out_byte_d;
	logic                       out_bv_d;
	logic                       out_last_d;

	always_comb begin
		if (pat_len_q == '0)
			plen = sfr_pkg::LEN_W'(1);
		else if (pat_len_q > sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN))
			plen = sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN);
		else
			plen = pat_len_q;
		if (rep_len_q > sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACEMENT))
			rlen = sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACEMENT);
		else
			rlen = rep_len_q;
	end

	always_comb begin
		match = 1'b1;
		for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin
			if (sfr_pkg::LEN_W'(i) < plen &&
				w_q[i] != sfr_pkg::reg_byte(pat_q, sfr_pkg::LEN_W'(i)))
				match = 1'b0;
		end
	end

	always_comb begin
		for (int k = 0; k < sfr_pkg::WIN_DEPTH; k++) begin
			if (k + int'(plen) < sfr_pkg::WIN_DEPTH)
				w_drop[k] = w_q[sfr_pkg::WIN_W'(k + int'(plen))];
			else
				w_drop[k] = w_q[k];
		end
	end

	assign need  = (ww_q && !last_q) ? sfr_pkg::FILL_W'(plen) + 1'b1 : sfr_pkg::FILL_W'(plen);
	assign after = (fill_q > sfr_pkg::FILL_W'(plen)) &&
		sfr_pkg::is_alnum(w_q[sfr_pkg::WIN_W'(plen)]);
	assign take  = !ww_q || (!before_q && !after);
	assign total = sfr_pkg::SUM_W'(cnt_q) + sfr_pkg::SUM_W'(rlen) +
		sfr_pkg::SUM_W'(fill_q - sfr_pkg::FILL_W'(plen));

	assign out_free = !out_vld_q || !result_stall;
	assign put      = cmd.put_w0 || cmd.put_rep;
	assign put_data = cmd.put_rep ? sfr_pkg::reg_byte(rep_q, idx_q) : w_q[0];

	always_comb begin
		sts.last         = last_q;
		sts.fill_ge_need = fill_q >= need;
		sts.fill_zero    = fill_q == '0;
		sts.match        = match;
		sts.take_ok      = take && (total <= sfr_pkg::SUM_W'(sfr_pkg::RESULT_CAP));
		sts.rlen_zero    = rlen == '0;
		sts.rep_end      = (idx_q + 1'b1) == rlen;
		sts.copy_end     = (idx_q + 1'b1) == plen;
		sts.put_ok       = last_q ? (!pend_vld_q || out_free) : out_free;
		sts.fin_ok       = out_free;
	end

	always_comb begin
		out_load   = 1'b0;
		out_byte_d = put_data;
		out_bv_d   = 1'b1;
		out_last_d = 1'b0;
		if (cmd.fin) begin
			out_load   = 1'b1;
			out_byte_d = pend_vld_q ? pend_q : 8'h00;
			out_bv_d   = pend_vld_q;
			out_last_d = 1'b1;
		end else if (put) begin
			if (last_q) begin
				out_load   = pend_vld_q;
				out_byte_d = pend_q;
			end else begin
				out_load = 1'b1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q     <= '0;
			pat_len_q <= sfr_pkg::LEN_W'(1);
			rep_q     <= '0;
			rep_len_q <= '0;
			ww_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				sfr_pkg::CFG_PAT_BYTES: pat_q     <= cfg_data;
				sfr_pkg::CFG_PAT_LEN:   pat_len_q <= cfg_data[sfr_pkg::LEN_W-1:0];
				sfr_pkg::CFG_REP_BYTES: rep_q     <= cfg_data;
				sfr_pkg::CFG_REP_LEN:   rep_len_q <= cfg_data[sfr_pkg::LEN_W-1:0];
				sfr_pkg::CFG_WHOLE_WRD: ww_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// window payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (fill_q < sfr_pkg::FILL_W'(sfr_pkg::WIN_DEPTH))
				w_q[sfr_pkg::WIN_W'(fill_q)] <= text_byte;
		end else if (cmd.shift1) begin
			for (int k = 0; k < sfr_pkg::WIN_DEPTH - 1; k++)
				w_q[k] <= w_q[k+1];
		end else if (cmd.drop) begin
			for (int k = 0; k < sfr_pkg::WIN_DEPTH; k++)
				w_q[k] <= w_drop[k];
		end
	end

	// window control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			before_q <= 1'b0;
			last_q   <= 1'b0;
			cnt_q    <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.load) begin
				if (fill_q < sfr_pkg::FILL_W'(sfr_pkg::WIN_DEPTH))
					fill_q <= fill_q + 1'b1;
				last_q <= text_last;
				cnt_q  <= '0;
			end else if (cmd.fin) begin
				fill_q   <= '0;
				before_q <= 1'b0;
			end else if (cmd.shift1) begin
				fill_q   <= fill_q - 1'b1;
				before_q <= sfr_pkg::is_alnum(w_q[0]);
			end else if (cmd.drop) begin
				fill_q   <= fill_q - sfr_pkg::FILL_W'(plen);
				before_q <= sfr_pkg::is_alnum(w_q[sfr_pkg::WIN_W'(plen - 1'b1)]);
			end
			if (put)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + 1'b1;
		end
	end

	// output register and one-deep holdback used on the final step of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			if (out_load)
				out_vld_q <= 1'b1;
			else if (out_free)
				out_vld_q <= 1'b0;
			if (cmd.fin)
				pend_vld_q <= 1'b0;
			else if (put && last_q)
				pend_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= out_byte_d;
			out_bv_q   <= out_bv_d;
			out_last_q <= out_last_d;
		end
		if (put && last_q)
			pend_q <= put_data;
	end

	assign result_valid = out_vld_q;
	assign emit_byte    = out_byte_q;
	assign emit_valid   = out_bv_q;
	assign emit_last    = out_last_q;

endmodule

[hw/rtl/sfr_ctrl.sv]
// controller state machine sequencing window scans, copies and replacements
module sfr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              text_valid,
	output logic              text_stall,
	input  sfr_pkg::sfr_sts_t sts,
	output sfr_pkg::sfr_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_SKIP  = 3'd2;
	localparam logic [2:0] ST_REPL  = 3'd3;
	localparam logic [2:0] ST_COPY  = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign text_stall = state_q != ST_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (text_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.idx_clr = 1'b1;
				if (sts.fill_ge_need) begin
					if (!sts.match) begin
						state_d = ST_SKIP;
					end else if (sts.take_ok) begin
						cmd.drop = 1'b1;
						state_d  = sts.rlen_zero ? ST_EVAL : ST_REPL;
					end else begin
						state_d = ST_COPY;
					end
				end else begin
					state_d = sts.last ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_SKIP: begin
				if (sts.put_ok) begin
					cmd.put_w0 = 1'b1;
					cmd.shift1 = 1'b1;
					state_d    = ST_EVAL;
				end
			end
			ST_REPL: begin
				if (sts.put_ok) begin
					cmd.put_rep = 1'b1;
					cmd.idx_inc = 1'b1;
					if (sts.rep_end)
						state_d = ST_EVAL;
				end
			end
			ST_COPY: begin
				if (sts.put_ok) begin
					cmd.put_w0  = 1'b1;
					cmd.shift1  = 1'b1;
					cmd.idx_inc = 1'b1;
					if (sts.copy_end)
						state_d = ST_EVAL;
				end
			end
			ST_FLUSH: begin
				if (sts.fill_zero) begin
					state_d = ST_FIN;
				end else if (sts.put_ok) begin
					cmd.put_w0 = 1'b1;
					cmd.shift1 = 1'b1;
				end
			end
			ST_FIN: begin
				if (sts.fin_ok) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

[hw/rtl/stream_find_replace.sv]
// top level of the streaming find-and-replace block
//
//  channel  handshake                  payload
//  text     text_valid / text_stall    text_byte, text_last
//  result   result_valid / result_stall emit_byte, emit_valid, emit_last
//  config   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// an input transaction that emits nothing is accepted in the idle state and then scanned in the eval state
// a mismatch passes one byte on in the skip state; a match emits the replacement or copies the pattern
// the last byte of a text then flushes the window, checks it is empty and sends the end marker
// all of this runs through one shared window compare in the datapath
// reset empties the window and restores the register reset values
// a stalled result holds the sequencer; the next input waits until its step is done
module stream_find_replace (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       text_valid,
	output logic                       text_stall,
	input  logic [7:0]                 text_byte,
	input  logic                       text_last,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [7:0]                 emit_byte,
	output logic                       emit_valid,
	output logic                       emit_last,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [sfr_pkg::CIDX_W-1:0] cfg_index,
	input  logic [sfr_pkg::REG_W-1:0]  cfg_data
);

	sfr_pkg::sfr_cmd_t cmd;
	sfr_pkg::sfr_sts_t sts;

	assign cfg_ready = 1'b1;

	sfr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	sfr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.text_byte    (text_byte),
		.text_last    (text_last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.emit_byte    (emit_byte),
		.emit_valid   (emit_valid),
		.emit_last    (emit_last)
	);

endmodule

[tb/tb_stream_find_replace.sv]
// self-checking testbench for the streaming find-and-replace block
module tb_stream_find_replace;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [sfr_pkg::CIDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
	} text_item_t;

	typedef struct packed {
		logic [7:0] b;
		logic       v;
		logic       l;
	} emit_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       text_valid = 1'b0;
	logic                       text_stall;
	logic [7:0]                 text_byte = 8'h00;
	logic                       text_last = 1'b0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic [7:0]                 emit_byte;
	logic                       emit_valid;
	logic                       emit_last;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [sfr_pkg::CIDX_W-1:0] cfg_index = '0;
	logic [sfr_pkg::REG_W-1:0]  cfg_data = '0;

	// settings mirrored from the register writes
	logic [63:0] cfg_pat = '0;
	logic [3:0]  cfg_pat_len = 4'd1;
	logic [63:0] cfg_rep = '0;
	logic [3:0]  cfg_rep_len = 4'd0;
	logic        cfg_whole = 1'b0;

	// undecided bytes of the text, oldest first
	logic [7:0] window [0:sfr_pkg::WIN_DEPTH-1];
	int         win_fill = 0;
	logic       prev_word = 1'b0;

	text_item_t text_queue [$];
	emit_t      edit_queue [$];
	text_item_t drive_item;
	emit_t      seen_item;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int err_count = 0;
	int items_queued = 0;

	stream_find_replace dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_byte(text_byte),
		.text_last(text_last),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.emit_byte(emit_byte),
		.emit_valid(emit_valid),
		.emit_last(emit_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic is_word_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic int clamp_len(input logic [3:0] l, input int lo, input int hi);
		int n;
		n = int'(l);
		if (n < lo)
			n = lo;
		if (n > hi)
			n = hi;
		return n;
	endfunction

	function automatic void shift_window(input int k);
		int i;
		if (k >= win_fill) begin
			win_fill = 0;
		end else begin
			for (i = 0; i < win_fill - k; i++)
				window[i] = window[i + k];
			win_fill -= k;
		end
	endfunction

	// edited text items caused by one accepted text byte
	function automatic void edit_text_byte(input logic [7:0] b, input logic last);
		emit_t outb [0:31];
		int    plen, rlen, need, cnt, i;
		logic  hit, take, after;
		plen = clamp_len(cfg_pat_len, 1, sfr_pkg::MAX_PATTERN);
		rlen = clamp_len(cfg_rep_len, 0, sfr_pkg::MAX_REPLACEMENT);
		cnt = 0;
		if (win_fill < sfr_pkg::WIN_DEPTH) begin
			window[win_fill] = b;
			win_fill++;
		end
		need = (cfg_whole && !last) ? plen + 1 : plen;
		while (win_fill >= need) begin
			hit = 1'b1;
			for (i = 0; i < plen; i++)
				if (window[i] != cfg_pat[8*i +: 8])
					hit = 1'b0;
			if (!hit) begin
				outb[cnt] = {window[0], 1'b1, 1'b0};
				cnt++;
				prev_word = is_word_char(window[0]);
				shift_window(1);
			end else begin
				take = 1'b1;
				if (cfg_whole) begin
					after = (win_fill > plen) && is_word_char(window[plen]);
					take = !prev_word && !after;
				end
				if (take && cnt + rlen + (win_fill - plen) <= sfr_pkg::RESULT_CAP) begin
					for (i = 0; i < rlen; i++) begin
						outb[cnt] = {cfg_rep[8*i +: 8], 1'b1, 1'b0};
						cnt++;
					end
				end else begin
					for (i = 0; i < plen; i++) begin
						outb[cnt] = {window[i], 1'b1, 1'b0};
						cnt++;
					end
				end
				prev_word = is_word_char(window[plen - 1]);
				shift_window(plen);
			end
		end
		if (last) begin
			for (i = 0; i < win_fill; i++) begin
				outb[cnt] = {window[i], 1'b1, 1'b0};
				cnt++;
			end
			win_fill = 0;
			prev_word = 1'b0;
			if (cnt == 0) begin
				outb[0] = {8'h00, 1'b0, 1'b1};
				cnt = 1;
			end else begin
				outb[cnt - 1].l = 1'b1;
			end
		end
		for (i = 0; i < cnt; i++)
			edit_queue.push_back(outb[i]);
	endfunction

	// text driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
			text_byte <= 8'h00;
			text_last <= 1'b0;
		end else begin
			if (text_valid && !text_stall)
				edit_text_byte(text_byte, text_last);
			if (!text_valid || !text_stall) begin
				if (text_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
					drive_item = text_queue.pop_front();
					text_valid <= 1'b1;
					text_byte <= drive_item.b;
					text_last <= drive_item.l;
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// result stall, with a counted long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (edit_queue.size() == 0) begin
				$error("result transaction with nothing expected: emit_byte %0h", emit_byte);
				err_count++;
			end else begin
				seen_item = edit_queue.pop_front();
				if (emit_byte !== seen_item.b) begin
					$error("emit_byte expected %0h actual %0h", seen_item.b, emit_byte);
					err_count++;
				end
				if (emit_valid !== seen_item.v) begin
					$error("emit_valid expected %0b actual %0b", seen_item.v, emit_valid);
					err_count++;
				end
				if (emit_last !== seen_item.l) begin
					$error("emit_last expected %0b actual %0b", seen_item.l, emit_last);
					err_count++;
				end
			end
		end
	end

	task automatic write_reg(input logic [sfr_pkg::CIDX_W-1:0] idx, input logic [63:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			sfr_pkg::CFG_PAT_BYTES: cfg_pat = val;
			sfr_pkg::CFG_PAT_LEN:   cfg_pat_len = val[3:0];
			sfr_pkg::CFG_REP_BYTES: cfg_rep = val;
			sfr_pkg::CFG_REP_LEN:   cfg_rep_len = val[3:0];
			sfr_pkg::CFG_WHOLE_WRD: cfg_whole = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [63:0] pat, input logic [3:0] plen,
		input logic [63:0] rep, input logic [3:0] rlen, input logic ww);
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		write_reg(sfr_pkg::CFG_PAT_BYTES, pat);
		write_reg(sfr_pkg::CFG_PAT_LEN, {noise[63:4], plen});
		write_reg(sfr_pkg::CFG_REP_BYTES, rep);
		write_reg(sfr_pkg::CFG_REP_LEN, {noise[59:0], rlen});
		write_reg(sfr_pkg::CFG_WHOLE_WRD, {noise[62:0], ww});
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drain;
		while (text_queue.size() != 0 || text_valid || edit_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle;
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		text_queue.push_back({b, last});
		items_queued++;
	endtask

	task automatic push_word(input string s, input logic last);
		int i;
		for (i = 0; i < s.len(); i++)
			push_byte(s[i], last && (i == s.len() - 1));
	endtask

	function automatic logic [7:0] pick_char;
		case ($urandom_range(7))
			0: return "a";
			1: return "b";
			2: return "c";
			3: return "1";
			4: return " ";
			5: return "-";
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic random_config(input int plen_hi);
		logic [63:0] pat, rep;
		int          k;
		for (k = 0; k < 8; k++) begin
			pat[8*k +: 8] = pick_char();
			rep[8*k +: 8] = ($urandom_range(1) != 0) ? 8'("X") + 8'(k) :
				8'($urandom_range(255));
		end
		apply_config(pat, 4'($urandom_range(1, plen_hi)), rep,
			4'($urandom_range(0, sfr_pkg::MAX_REPLACEMENT)), 1'($urandom_range(1)));
	endtask

	// text with random content and planted full or partial pattern copies
	task automatic queue_text(input int len, input bit pause_midway);
		logic [7:0] body [$];
		int         i, k, n, r, plen;
		plen = clamp_len(cfg_pat_len, 1, sfr_pkg::MAX_PATTERN);
		for (i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (r < 30) begin
				for (k = 0; k < plen; k++)
					body.push_back(cfg_pat[8*k +: 8]);
			end else if (r < 42) begin
				n = $urandom_range(1, plen);
				for (k = 0; k < n; k++)
					body.push_back(cfg_pat[8*k +: 8]);
			end else if (r < 85) begin
				body.push_back(pick_char());
			end else begin
				body.push_back(8'($urandom_range(255)));
			end
		end
		for (i = 0; i < body.size(); i++) begin
			push_byte(body[i], i == body.size() - 1);
			if (pause_midway && i == body.size() / 2 && body.size() > 1)
				wait_drain();
		end
	endtask

	task automatic run_phase(input int quota, input int plen_hi, input bit pause_once);
		int start;
		start = items_queued;
		while (items_queued - start < quota) begin
			queue_text(($urandom_range(9) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 14), pause_once);
			pause_once = 1'b0;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed texts
		apply_config(64'h6261, 4'd2, 64'h5A5958, 4'd3, 1'b0);
		push_word("ab", 1'b1);
		push_byte(8'h00, 1'b0);
		push_word("aab", 1'b0);
		push_byte(8'hFF, 1'b1);
		settle();
		apply_config(64'h6261, 4'd2, 64'h0, 4'd0, 1'b0);
		push_word("ab", 1'b1);
		settle();
		apply_config(64'h6261, 4'd2, 64'h2D, 4'd1, 1'b1);
		push_word("ab xab", 1'b1);
		settle();
		apply_config(64'h7A, 4'd0, 64'h3231, 4'd2, 1'b0);
		push_word("zz", 1'b1);
		settle();
		write_reg(CFG_UNUSED, {$urandom, $urandom});
		apply_config('1, 4'd15, {$urandom, $urandom}, 4'd15, 1'b0);
		repeat (8) push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		settle();

		// random texts under several settings and traffic shapes
		random_config(4);
		run_phase(36, 4, 1'b0);
		settle();
		random_config(sfr_pkg::MAX_PATTERN);
		idle_pct <= 46;
		run_phase(36, 4, 1'b0);
		settle();
		random_config(4);
		idle_pct <= 0;
		stall_pct <= 46;
		run_phase(36, 4, 1'b1);
		settle();
		random_config(3);
		idle_pct <= 9;
		stall_pct <= 9;
		run_phase(36, 3, 1'b0);
		settle();
		apply_config(64'h61, 4'd1, 64'h0, 4'd0, 1'b0);
		idle_pct <= 0;
		stall_pct <= 0;
		hold_req <= hold_req + 1;
		run_phase(36, 1, 1'b0);
		settle();
		apply_config(64'h6261_6161_6261_6261, 4'd8, 64'h4847_4645_4443_4241, 4'd8, 1'b1);
		idle_pct <= 9;
		stall_pct <= 9;
		run_phase(36, 8, 1'b0);
		settle();
		random_config(2);
		idle_pct <= 46;
		stall_pct <= 46;
		run_phase(20, 2, 1'b0);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (err_count == 0 && edit_queue.size() == 0)
			$display("stream_find_replace verification clean");
		else
			$display("stream_find_replace verification failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("stream_find_replace verification failed");
		$finish;
	end

endmodule
